// ===== hdl/itaf_pkg.sv =====
// Shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies; every other file of the block refers to this package by scoped names.
package itaf_pkg;

    // Character buffer: one slot stays unused, so the text holds at most CAPACITY chars.
    localparam int BUFFER_SIZE = 16;
    localparam int CAPACITY    = BUFFER_SIZE - 1;
    localparam int CNT_W       = $clog2(BUFFER_SIZE);

    localparam int VALUE_W = 32;
    localparam int WIDTH_W = 4;
    localparam int CHAR_W  = 8;
    localparam int OUT_W   = 7;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [VALUE_W-1:0] SIGN_MASK = 32'h8000_0000;

    // Divide by ten: q = (v * RECIP) >> SHIFT is exact over all 32-bit v.
    localparam logic [VALUE_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int                 DEC_SHIFT = 35;
    localparam int                 HEX_SHIFT = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] HEX_GAP     = 8'h07;

    // One classified directive: magnitude already taken, sign split off.
    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               hex;
        logic               neg;
        logic [WIDTH_W-1:0] width;
        logic               zp;
    } t_job;

    // Digit value 0..15 to its ASCII code, upper-case letters above nine.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        c = ASCII_ZERO + {4'b0000, d};
        if (c > ASCII_NINE) begin
            c = c + HEX_GAP;
        end
        return c;
    endfunction

endpackage

// ===== hdl/itaf_front.sv =====
// Front end: takes a directive, resolves sign and magnitude, holds it in one register stage.
// Depends on itaf_pkg.
module itaf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [itaf_pkg::VALUE_W-1:0] i_value,
    input  logic                      i_radix_hex,
    input  logic                      i_is_signed,
    input  logic [itaf_pkg::WIDTH_W-1:0] i_field_width,
    input  logic                      i_zero_pad,
    output logic                      o_valid,
    input  logic                      i_ready,
    output itaf_pkg::t_job            o_job
);

    logic           r_valid;
    itaf_pkg::t_job r_job;
    itaf_pkg::t_job n_job;
    logic           neg;

    // Only signed decimal with the top bit set is printed with a minus sign.
    assign neg = !i_radix_hex && i_is_signed && ((i_value & itaf_pkg::SIGN_MASK) != '0);

    always_comb begin
        n_job.mag   = neg ? (~i_value + 1'b1) : i_value;
        n_job.hex   = i_radix_hex;
        n_job.neg   = neg;
        n_job.width = i_field_width;
        n_job.zp    = i_zero_pad;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== hdl/itaf_queue.sv =====
// Short job queue that decouples the front end from the formatting engine.
// Depends on itaf_pkg.
module itaf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  itaf_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output itaf_pkg::t_job o_job
);

    itaf_pkg::t_job              r_mem [itaf_pkg::QUEUE_DEPTH];
    logic [itaf_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [itaf_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [itaf_pkg::QPTR_W:0]   r_count;
    logic                        push;
    logic                        pop;

    assign o_ready = (r_count != (itaf_pkg::QPTR_W+1)'(itaf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    function automatic logic [itaf_pkg::QPTR_W-1:0] ptr_inc(
        input logic [itaf_pkg::QPTR_W-1:0] p
    );
        return (p == itaf_pkg::QPTR_W'(itaf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (itaf_pkg::QPTR_W+1)'(itaf_pkg::QUEUE_DEPTH))
        else $error("job queue count out of range");
    a_pop_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_rd_ptr != $past(r_rd_ptr) || itaf_pkg::QUEUE_DEPTH == 1)
        else $error("read pointer did not advance on pop");
`endif

endmodule

// ===== hdl/itaf_back.sv =====
// Formatting engine: digit extraction, padding, and reversed character output.
// Depends on itaf_pkg.
module itaf_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  itaf_pkg::t_job            i_job,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [itaf_pkg::OUT_W-1:0] o_char,
    output logic                      o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIG,
        S_PAD,
        S_EMIT
    } t_state;

    localparam int CNT_W  = itaf_pkg::CNT_W;
    localparam int VAL_W  = itaf_pkg::VALUE_W;
    localparam int CHAR_W = itaf_pkg::CHAR_W;

    t_state                        r_state, n_state;
    logic [VAL_W-1:0]              r_val, n_val;
    logic [2*VAL_W-1:0]            r_prod, n_prod;
    logic                          r_hex, n_hex;
    logic                          r_neg, n_neg;
    logic [itaf_pkg::WIDTH_W-1:0]  r_width, n_width;
    logic                          r_zp, n_zp;
    logic [CNT_W-1:0]              r_n, n_n;
    logic                          r_out_valid, n_out_valid;
    logic [itaf_pkg::OUT_W-1:0]    r_out_char, n_out_char;
    logic                          r_out_last, n_out_last;

    logic [CHAR_W-1:0]             r_buf [itaf_pkg::BUFFER_SIZE];
    logic                          wr_en;
    logic [CHAR_W-1:0]             wr_char;

    logic [VAL_W-1:0]              q_dec;
    logic [VAL_W-1:0]              rem_dec;
    logic [VAL_W-1:0]              quot;
    logic [3:0]                    digit;
    logic [CNT_W-1:0]              width_ext;
    logic [CNT_W-1:0]              target;
    logic                          has_room;
    logic                          out_free;
    logic [CHAR_W-1:0]             rd_char;

    // Quotient by ten from the registered reciprocal product, remainder by shift-add.
    assign q_dec   = VAL_W'(r_prod[2*VAL_W-1:itaf_pkg::DEC_SHIFT]);
    assign rem_dec = r_val - ((q_dec << 3) + (q_dec << 1));
    assign quot    = r_hex ? (r_val >> itaf_pkg::HEX_SHIFT) : q_dec;
    assign digit   = r_hex ? r_val[3:0] : rem_dec[3:0];

    assign width_ext = CNT_W'(r_width);
    assign target    = (r_neg && r_width != '0) ? width_ext - 1'b1 : width_ext;
    assign has_room  = (r_n < CNT_W'(itaf_pkg::CAPACITY));
    assign out_free  = !r_out_valid || i_ready;
    assign rd_char   = r_buf[r_n - 1'b1];

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_prod      = r_prod;
        n_hex       = r_hex;
        n_neg       = r_neg;
        n_width     = r_width;
        n_zp        = r_zp;
        n_n         = r_n;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_char     = itaf_pkg::ASCII_ZERO;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val   = i_job.mag;
                    n_hex   = i_job.hex;
                    n_neg   = i_job.neg;
                    n_width = i_job.width;
                    n_zp    = i_job.zp;
                    n_n     = '0;
                    n_state = i_job.hex ? S_DIG : S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = (2*VAL_W)'(r_val) * (2*VAL_W)'(itaf_pkg::DEC_RECIP);
                n_state = S_DIG;
            end
            S_DIG: begin
                wr_en   = 1'b1;
                wr_char = itaf_pkg::digit_char(digit);
                n_n     = r_n + 1'b1;
                n_val   = quot;
                // at least one digit; stop on zero quotient or full buffer
                if (quot != '0 && r_n < CNT_W'(itaf_pkg::CAPACITY - 1)) begin
                    n_state = r_hex ? S_DIG : S_MUL;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (r_zp) begin
                    // zeros first, then the sign ahead of them
                    if (has_room && r_n < target) begin
                        wr_en   = 1'b1;
                        wr_char = itaf_pkg::ASCII_ZERO;
                        n_n     = r_n + 1'b1;
                    end else begin
                        if (r_neg && has_room) begin
                            wr_en   = 1'b1;
                            wr_char = itaf_pkg::ASCII_MINUS;
                            n_n     = r_n + 1'b1;
                        end
                        n_state = S_EMIT;
                    end
                end else begin
                    if (r_neg && has_room) begin
                        wr_en   = 1'b1;
                        wr_char = itaf_pkg::ASCII_MINUS;
                        n_n     = r_n + 1'b1;
                        n_neg   = 1'b0;
                    end else if (has_room && r_n < width_ext) begin
                        wr_en   = 1'b1;
                        wr_char = itaf_pkg::ASCII_SPACE;
                        n_n     = r_n + 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                // buffer holds least significant first; drain from the top
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = rd_char[itaf_pkg::OUT_W-1:0];
                    n_out_last  = (r_n == CNT_W'(1));
                    n_n         = r_n - 1'b1;
                    if (r_n == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_val       <= '0;
            r_n         <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_val       <= n_val;
            r_n         <= n_n;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
        r_prod     <= n_prod;
        r_hex      <= n_hex;
        r_width    <= n_width;
        r_zp       <= n_zp;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_n] <= wr_char;
        end
    end

`ifndef SYNTHESIS
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(itaf_pkg::CAPACITY))
        else $error("fill index beyond capacity");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_n != '0)
        else $error("emit with empty buffer");
    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && out_free && r_n == CNT_W'(1) |=> r_state == S_IDLE && r_out_last)
        else $error("final character not marked");
    a_no_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT || r_state == S_IDLE |-> !wr_en)
        else $error("buffer written outside fill phase");
`endif

endmodule

// ===== hdl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: stream ports, front end, job queue, engine.
// Depends on itaf_pkg, itaf_front, itaf_queue and itaf_back.
//
// Formats one numeric directive (32-bit value, decimal or upper-case hex, signed flag,
// field width 0..15, zero/space pad) into ASCII characters, most significant first, with
// tlast on the final character. Signed decimal values with bit 31 set print as a minus
// sign and the magnitude (0x80000000 prints as -2147483648); the signed flag is ignored
// for hex. Padding goes on the left; zero padding sits after the minus sign. Output is
// at most 15 characters. Per transaction the engine takes the job, extracts each decimal
// digit by a reciprocal multiply and then quotient/remainder, or each hex digit by a shift,
// writes each pad character and then closes padding, and emits the characters while the
// sink is ready. Directives pass the front register and the queue ahead of the engine.
// A register stage and a two-entry job queue in front of the engine keep accepting
// directives while one is being formatted.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [35:32] field_width, [39:36] zero
    input  logic [2:0]  s_axis_tuser,   // [0] radix_hex, [1] is_signed, [2] zero_pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero
    output logic        m_axis_tlast    // last character of this number
);

    logic                        front_valid;
    logic                        front_ready;
    itaf_pkg::t_job              front_job;
    logic                        queue_valid;
    logic                        queue_ready;
    itaf_pkg::t_job              queue_job;
    logic [itaf_pkg::OUT_W-1:0]  out_char;

    // Sign resolution and magnitude, one register stage.
    itaf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_value       (s_axis_tdata[31:0]),
        .i_radix_hex   (s_axis_tuser[0]),
        .i_is_signed   (s_axis_tuser[1]),
        .i_field_width (s_axis_tdata[35:32]),
        .i_zero_pad    (s_axis_tuser[2]),
        .o_valid       (front_valid),
        .i_ready       (front_ready),
        .o_job         (front_job)
    );

    // Decouples intake from the engine.
    itaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_job   (front_job),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_job   (queue_job)
    );

    // Digit extraction, padding and character output with its own output register.
    itaf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_job   (queue_job),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (out_char),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

// ===== bench/integer_to_ascii_formatter_tb.sv =====
// Self-checking bench for integer_to_ascii_formatter: directed and random directives,
// predicted character streams compared one transaction at a time. Needs only itaf_pkg and the RTL.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;

    // Run limit in clock cycles. Slowest legal run: ~280 directives at up to 15 characters,
    // each character waiting out a 70% idle sink, plus the long sink hold-off; the limit
    // takes that several times over.
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned TAIL_CYCLES  = 64;     // above the worst-case latency
    localparam int unsigned MAX_REPORTED = 10;

    // One expected output transaction.
    typedef struct packed {
        logic [itaf_pkg::OUT_W-1:0] ch;
        logic                       last;
    } t_char_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // [31:0] value, [35:32] field_width, [39:36] zero
    logic [2:0]  s_axis_tuser = '0;    // [0] radix_hex, [1] is_signed, [2] zero_pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [6:0] character, [7] zero
    logic        m_axis_tlast;

    t_char_exp   expected_chars[$];
    int unsigned numbers_sent = 0;
    int unsigned chars_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned neg_numbers = 0;
    int unsigned hex_numbers = 0;

    // Idle percentages per cycle for the source and sink sides.
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    // Long sink hold-off: the test loads it, the sink process counts it down.
    int unsigned sink_hold_cycles = 0;

    integer_to_ascii_formatter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: builds the text least significant character first, then
    // queues it most significant first with the last flag on the final one.
    // ------------------------------------------------------------------
    function automatic void predict_text(input logic [itaf_pkg::VALUE_W-1:0] value,
                                         input logic hex, input logic sgn,
                                         input logic [itaf_pkg::WIDTH_W-1:0] width,
                                         input logic zp);
        logic [itaf_pkg::CHAR_W-1:0]  text [0:itaf_pkg::BUFFER_SIZE-1];
        logic [itaf_pkg::VALUE_W-1:0] mag;
        logic [itaf_pkg::VALUE_W-1:0] base;
        logic [itaf_pkg::VALUE_W-1:0] rem;
        logic [itaf_pkg::CHAR_W-1:0]  c;
        logic                         neg;
        int                           n;
        int                           goal;
        t_char_exp                    item;
        mag  = value;
        neg  = 1'b0;
        n    = 0;
        base = hex ? 32'd16 : 32'd10;
        // Signed decimal with the sign bit set: print the magnitude behind a minus.
        // The most negative value negates to itself and still reads as 2147483648.
        if (!hex && sgn && value[itaf_pkg::VALUE_W-1]) begin
            mag = 32'd0 - value;
            neg = 1'b1;
        end
        // Zero still yields one digit.
        do begin
            rem = mag % base;
            c = itaf_pkg::ASCII_ZERO + {4'b0000, rem[3:0]};
            if (c > itaf_pkg::ASCII_NINE) begin
                c = c + itaf_pkg::HEX_GAP;
            end
            text[n] = c;
            n++;
            mag = mag / base;
        end while (n < itaf_pkg::CAPACITY && mag != 0);
        if (zp) begin
            // Zeros go between the minus sign and the digits.
            goal = (neg && width > 0) ? int'(width) - 1 : int'(width);
            while (n < itaf_pkg::CAPACITY && n < goal) begin
                text[n] = itaf_pkg::ASCII_ZERO;
                n++;
            end
            if (neg && n < itaf_pkg::CAPACITY) begin
                text[n] = itaf_pkg::ASCII_MINUS;
                n++;
            end
        end else begin
            if (neg && n < itaf_pkg::CAPACITY) begin
                text[n] = itaf_pkg::ASCII_MINUS;
                n++;
            end
            while (n < itaf_pkg::CAPACITY && n < int'(width)) begin
                text[n] = itaf_pkg::ASCII_SPACE;
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            item.ch   = text[n - 1 - k][itaf_pkg::OUT_W-1:0];
            item.last = (k == n - 1);
            expected_chars.push_back(item);
        end
        if (neg) neg_numbers++;
        if (hex) hex_numbers++;
    endfunction

    // ------------------------------------------------------------------
    // Source side: one directive per call. valid stays high across back-to-back
    // calls and only drops when the source decides to idle.
    // ------------------------------------------------------------------
    task automatic send_number(input logic [itaf_pkg::VALUE_W-1:0] value, input logic hex,
                               input logic sgn, input logic [itaf_pkg::WIDTH_W-1:0] width,
                               input logic zp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, width, value};
        s_axis_tuser  <= {zp, sgn, hex};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        // Transaction taken at this edge.
        predict_text(value, hex, sgn, width, zp);
        numbers_sent++;
    endtask

    // Source pause: drop valid and wait until every predicted character has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_chars.size() != 0);
    endtask

    // Random value: mostly interesting shapes, some fully random bit patterns.
    function automatic logic [itaf_pkg::VALUE_W-1:0] pick_value();
        logic [itaf_pkg::VALUE_W-1:0] p;
        case ($urandom_range(0, 6))
            0: pick_value = $urandom_range(0, 99);
            1: pick_value = 32'd0 - $urandom_range(1, 1000);
            2: begin
                // Around a power of ten, where the digit count changes.
                p = 32'd1;
                repeat ($urandom_range(1, 9)) p = p * 10;
                pick_value = p + $urandom_range(0, 2) - 1;
            end
            3: pick_value = itaf_pkg::SIGN_MASK + $urandom_range(0, 3) - 1;
            4: pick_value = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: pick_value = $urandom();
        endcase
    endfunction

    task automatic send_random_number();
        send_number(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    itaf_pkg::WIDTH_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, both radices, signed handling and every padding corner.
    task automatic test_directed_cases();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_number(32'd0,          1'b0, 1'b0, 4'd0,  1'b0);  // zero -> "0"
        send_number(32'd0,          1'b1, 1'b1, 4'd0,  1'b1);  // zero in hex
        send_number(32'hFFFF_FFFF,  1'b0, 1'b0, 4'd0,  1'b0);  // 4294967295
        send_number(32'hFFFF_FFFF,  1'b1, 1'b0, 4'd0,  1'b0);  // FFFFFFFF
        send_number(32'hFFFF_FFFF,  1'b0, 1'b1, 4'd0,  1'b0);  // -1
        send_number(32'h8000_0000,  1'b0, 1'b1, 4'd0,  1'b0);  // most negative
        send_number(32'h8000_0000,  1'b0, 1'b1, 4'd15, 1'b1);  // most negative, zero-filled
        send_number(32'h8000_0000,  1'b0, 1'b1, 4'd15, 1'b0);  // most negative, space-filled
        send_number(32'h8000_0000,  1'b1, 1'b1, 4'd0,  1'b0);  // signed flag ignored for hex
        send_number(32'h7FFF_FFFF,  1'b0, 1'b1, 4'd0,  1'b0);  // largest positive signed
        send_number(32'hFFFF_FFD6,  1'b0, 1'b1, 4'd5,  1'b1);  // -42 -> "-0042"
        send_number(32'hFFFF_FFD6,  1'b0, 1'b1, 4'd5,  1'b0);  // -42 -> "  -42"
        send_number(32'hFFFF_FFFB,  1'b0, 1'b1, 4'd1,  1'b1);  // width 1 with minus
        send_number(32'd12345,      1'b0, 1'b0, 4'd3,  1'b1);  // width below content
        send_number(32'd12345,      1'b0, 1'b0, 4'd5,  1'b0);  // width equals content
        send_number(32'd7,          1'b0, 1'b0, 4'd15, 1'b0);  // full space fill
        send_number(32'd7,          1'b0, 1'b1, 4'd15, 1'b1);  // positive signed, zero fill
        send_number(32'hABCD_EF01,  1'b1, 1'b0, 4'd15, 1'b1);  // hex letters, zero fill
        send_number(32'h1234_5678,  1'b1, 1'b1, 4'd10, 1'b0);  // hex, space fill
        send_number(32'h0000_00FA,  1'b1, 1'b0, 4'd4,  1'b1);  // short hex, zero fill
        send_number(32'd1_000_000_000, 1'b0, 1'b0, 4'd12, 1'b1);
        send_number(32'd999_999_999,   1'b0, 1'b0, 4'd0,  1'b0);
        wait_drained();
    endtask

    task automatic test_random_numbers(input int unsigned count, input int unsigned src_pct,
                                       input int unsigned sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count) send_random_number();
        wait_drained();
    endtask

    // Sink holds off for a long stretch while the source keeps offering: the job
    // queue fills and s_axis_tready must drop. Afterwards the source waits for drain.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        @(posedge i_clk);
        sink_hold_cycles <= 300;
        repeat (12) begin
            send_number(32'h8000_0000 | $urandom(), 1'b0, 1'b1, 4'd15,
                        1'($urandom_range(0, 1)));
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sink side: random idling, or a counted hold-off when one is loaded.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold_cycles != 0) begin
            m_axis_tready    <= 1'b0;
            sink_hold_cycles <= sink_hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Output checker: every accepted character against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_chars
        t_char_exp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED) begin
                    $display("[%0t] unexpected character 0x%02h last=%0b, nothing predicted",
                             $realtime, m_axis_tdata[itaf_pkg::OUT_W-1:0], m_axis_tlast);
                end
            end else begin
                want = expected_chars.pop_front();
                if (m_axis_tdata[itaf_pkg::OUT_W-1:0] !== want.ch ||
                    m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED) begin
                        $display({"[%0t] character mismatch: expected 0x%02h last=%0b,",
                                  " got 0x%02h last=%0b"},
                                 $realtime, want.ch, want.last,
                                 m_axis_tdata[itaf_pkg::OUT_W-1:0], m_axis_tlast);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still predicted",
                     cycle_count, expected_chars.size());
            $display("integer_to_ascii_formatter verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_numbers(82, 9, 70);   // slow sink
        test_output_backpressure();
        test_random_numbers(82, 70, 9);   // slow source
        test_random_numbers(80, 0, 0);    // full rate both sides

        // Let anything stray come out before judging.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            mismatch_count++;
            $display("%0d predicted characters never arrived", expected_chars.size());
        end

        $display("Formatted %0d directives (%0d hex, %0d negative) into %0d characters,",
                 numbers_sent, hex_numbers, neg_numbers, chars_checked);
        $display("widths 0..15 with space and zero fill, under source, sink and long stalls.");
        if (mismatch_count == 0) begin
            $display("integer_to_ascii_formatter verification clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("integer_to_ascii_formatter verification failed");
        end
        $finish;
    end

endmodule
